// ===== rtl/hcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcw_pkg
// Shared types, widths and codes for the HEPv3 chunk walker.
// ----------------------------------------------------------------------------
package hcw_pkg;

  localparam int ByteW   = 8;
  localparam int Len16W  = 16;
  localparam int Word32W = 32;
  localparam int CountW  = 5;
  localparam int StatusW = 3;

  localparam logic [CountW-1:0] MinElementsReset = 5'd9;
  localparam logic [CountW-1:0] CountMax         = 5'd31;

  // Fixed chunk header length (vendor, type, length)
  localparam logic [Len16W-1:0] ChunkHdrLen = 16'd6;
  // Bytes of chunk data that can carry a captured value
  localparam logic [Len16W-1:0] ValueBytes  = 16'd4;
  // Message header length (magic + total length)
  localparam logic [Len16W-1:0] MsgHdrLen   = 16'd6;
  localparam logic [Len16W-1:0] PosMax      = 16'hFFFF;

  // Generic chunk types of interest
  localparam logic [Len16W-1:0] KindSrcPort  = 16'd7;
  localparam logic [Len16W-1:0] KindDstPort  = 16'd8;
  localparam logic [Len16W-1:0] KindSeconds  = 16'd9;
  localparam logic [Len16W-1:0] KindMicros   = 16'd10;
  localparam logic [Len16W-1:0] KindCapture  = 16'd12;
  localparam logic [Len16W-1:0] KindPayload  = 16'd15;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_FEW       = 3'd1,
    ST_BAD_CHUNK = 3'd2,
    ST_NOT_HEP3  = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  // One input word
  typedef struct packed {
    logic              last_byte;
    logic [ByteW-1:0]  message_byte;
  } hcw_item_t;

  // One result word; last field in the lowest bits
  typedef struct packed {
    logic [Len16W-1:0]  payload_length;
    logic [Len16W-1:0]  payload_offset;
    logic [Word32W-1:0] capture_id;
    logic [Word32W-1:0] microseconds;
    logic [Word32W-1:0] seconds;
    logic [Len16W-1:0]  destination_port;
    logic [Len16W-1:0]  source_port;
    logic [CountW-1:0]  element_count;
    status_t            status;
  } hcw_result_t;

  localparam int ResultW = $bits(hcw_result_t);

  // "HEP3" magic, by byte position
  function automatic logic [ByteW-1:0] hep_magic(input logic [1:0] pos);
    logic [ByteW-1:0] m;
    case (pos)
      2'd0:    m = 8'h48;
      2'd1:    m = 8'h45;
      2'd2:    m = 8'h50;
      default: m = 8'h33;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/hcw_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcw_in_stage
// Input register: holds one accepted byte until the parser takes it.
// ----------------------------------------------------------------------------
module hcw_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hcw_pkg::hcw_item_t in_item,
  input  logic               take,
  output logic               held_valid,
  output hcw_pkg::hcw_item_t held_item
);

  logic               valid_r, valid_nxt;
  hcw_pkg::hcw_item_t item_r,  item_nxt;

  assign in_ready   = !valid_r || take;
  assign held_valid = valid_r;
  assign held_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      if (in_valid) begin
        item_nxt = in_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ===== rtl/hcw_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcw_parser
// Message state and per-byte update: magic, length, chunk walk, captures,
// and the final status on the last byte.
// ----------------------------------------------------------------------------
module hcw_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  hcw_pkg::hcw_item_t            item,
  input  logic [hcw_pkg::CountW-1:0]    min_elements,
  output logic                          res_fire,
  output hcw_pkg::hcw_result_t          result
);

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_BAD  = 2'd1,
    ERR_NOT  = 2'd2
  } err_t;

  localparam int L = hcw_pkg::Len16W;
  localparam int W = hcw_pkg::Word32W;

  logic [L-1:0] bpos_r,   bpos_nxt;
  logic [L-1:0] mlen_r,   mlen_nxt;
  logic [7:0]   prev_r,   prev_nxt;
  logic [L-1:0] vendor_r, vendor_nxt;
  logic [L-1:0] kind_r,   kind_nxt;
  logic [L-1:0] size_r,   size_nxt;
  logic [L-1:0] cidx_r,   cidx_nxt;
  logic [W-1:0] vshift_r, vshift_nxt;
  logic [hcw_pkg::CountW-1:0] count_r, count_nxt;
  err_t         err_r,    err_nxt;
  logic [L-1:0] sport_r,  sport_nxt;
  logic [L-1:0] dport_r,  dport_nxt;
  logic [W-1:0] sec_r,    sec_nxt;
  logic [W-1:0] usec_r,   usec_nxt;
  logic [W-1:0] capt_r,   capt_nxt;
  logic [L-1:0] poff_r,   poff_nxt;
  logic [L-1:0] plen_r,   plen_nxt;

  always_comb begin
    logic [7:0]   b;
    logic [L-1:0] size_cur;
    logic [L-1:0] cidx_inc;
    logic [L-1:0] ndata;
    logic [W-1:0] vs_new;
    logic [W-1:0] v;
    logic [L:0]   end_pos;
    logic [L:0]   lim_pos;
    logic         hdr_bad;
    hcw_pkg::status_t st;

    b        = item.message_byte;
    size_cur = size_r;
    vs_new   = vshift_r;
    hdr_bad  = 1'b0;
    cidx_inc = cidx_r + 16'd1;
    ndata    = '0;
    v        = '0;
    end_pos  = '0;
    lim_pos  = '0;
    st       = hcw_pkg::ST_OK;

    bpos_nxt   = bpos_r;
    mlen_nxt   = mlen_r;
    prev_nxt   = prev_r;
    vendor_nxt = vendor_r;
    kind_nxt   = kind_r;
    size_nxt   = size_r;
    cidx_nxt   = cidx_r;
    vshift_nxt = vshift_r;
    count_nxt  = count_r;
    err_nxt    = err_r;
    sport_nxt  = sport_r;
    dport_nxt  = dport_r;
    sec_nxt    = sec_r;
    usec_nxt   = usec_r;
    capt_nxt   = capt_r;
    poff_nxt   = poff_r;
    plen_nxt   = plen_r;
    result     = '0;
    res_fire   = step && item.last_byte;

    if (step) begin
      if (bpos_r != hcw_pkg::PosMax) begin
        bpos_nxt = bpos_r + 16'd1;
      end
      if (err_r == ERR_NONE && bpos_r != hcw_pkg::PosMax) begin
        if (bpos_r < 16'd4) begin
          if (b != hcw_pkg::hep_magic(bpos_r[1:0])) begin
            err_nxt = ERR_NOT;
          end
        end else if (bpos_r < hcw_pkg::MsgHdrLen) begin
          prev_nxt = b;
          if (bpos_r == 16'd5) begin
            mlen_nxt = {prev_r, b};
          end
        end else if (bpos_r < mlen_r) begin
          // chunk walk
          if (cidx_r < hcw_pkg::ChunkHdrLen) begin
            prev_nxt = b;
            if (cidx_r == 16'd1) vendor_nxt = {prev_r, b};
            if (cidx_r == 16'd3) kind_nxt = {prev_r, b};
            if (cidx_r == 16'd5) begin
              size_cur = {prev_r, b};
              size_nxt = size_cur;
              // chunk must fit in what is left of the message
              end_pos  = {1'b0, size_cur} + {1'b0, bpos_r};
              lim_pos  = {1'b0, mlen_r} + 17'd5;
              hdr_bad  = (size_cur < hcw_pkg::ChunkHdrLen) ||
                         (vendor_r == '0 && kind_r == '0) ||
                         (end_pos > lim_pos);
            end
          end else if (cidx_r < hcw_pkg::ChunkHdrLen + hcw_pkg::ValueBytes) begin
            vs_new     = {vshift_r[W-9:0], b};
            vshift_nxt = vs_new;
          end

          if (hdr_bad) begin
            err_nxt = ERR_BAD;
          end else begin
            cidx_nxt = cidx_inc;
            if (cidx_inc >= hcw_pkg::ChunkHdrLen && cidx_inc == size_cur) begin
              cidx_nxt   = '0;
              vshift_nxt = '0;
              // left-align short values, missing low bytes read as zero
              ndata = size_cur - hcw_pkg::ChunkHdrLen;
              if (ndata >= hcw_pkg::ValueBytes) begin
                v = vs_new;
              end else begin
                case (ndata[1:0])
                  2'd3:    v = {vs_new[23:0], 8'h00};
                  2'd2:    v = {vs_new[15:0], 16'h0000};
                  2'd1:    v = {vs_new[7:0], 24'h000000};
                  default: v = '0;
                endcase
              end
              if (vendor_r == '0) begin
                if (((kind_r >= 16'd1 && kind_r <= hcw_pkg::KindCapture) ||
                     kind_r == hcw_pkg::KindPayload) && count_r != hcw_pkg::CountMax) begin
                  count_nxt = count_r + 5'd1;
                end
                if (kind_r == hcw_pkg::KindSrcPort) sport_nxt = v[W-1:L];
                if (kind_r == hcw_pkg::KindDstPort) dport_nxt = v[W-1:L];
                if (kind_r == hcw_pkg::KindSeconds) sec_nxt = v;
                if (kind_r == hcw_pkg::KindMicros)  usec_nxt = v;
                if (kind_r == hcw_pkg::KindCapture) capt_nxt = v;
                if (kind_r == hcw_pkg::KindPayload) begin
                  poff_nxt = bpos_r + 16'd7 - size_cur;
                  plen_nxt = ndata;
                end
              end
            end
          end
        end
      end

      if (item.last_byte) begin
        if (err_nxt == ERR_NOT)                    st = hcw_pkg::ST_NOT_HEP3;
        else if (bpos_nxt < hcw_pkg::MsgHdrLen)    st = hcw_pkg::ST_TRUNCATED;
        else if (err_nxt == ERR_BAD)               st = hcw_pkg::ST_BAD_CHUNK;
        else if (bpos_nxt < mlen_nxt)              st = hcw_pkg::ST_TRUNCATED;
        else if (cidx_nxt != '0)                   st = hcw_pkg::ST_BAD_CHUNK;
        else if (count_nxt < min_elements)         st = hcw_pkg::ST_FEW;
        else                                       st = hcw_pkg::ST_OK;

        result.status           = st;
        result.element_count    = count_nxt;
        result.source_port      = sport_nxt;
        result.destination_port = dport_nxt;
        result.seconds          = sec_nxt;
        result.microseconds     = usec_nxt;
        result.capture_id       = capt_nxt;
        result.payload_offset   = poff_nxt;
        result.payload_length   = plen_nxt;

        // message done: back to a clean slate
        bpos_nxt   = '0;
        mlen_nxt   = '0;
        prev_nxt   = '0;
        vendor_nxt = '0;
        kind_nxt   = '0;
        size_nxt   = '0;
        cidx_nxt   = '0;
        vshift_nxt = '0;
        count_nxt  = '0;
        err_nxt    = ERR_NONE;
        sport_nxt  = '0;
        dport_nxt  = '0;
        sec_nxt    = '0;
        usec_nxt   = '0;
        capt_nxt   = '0;
        poff_nxt   = '0;
        plen_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpos_r   <= '0;
      mlen_r   <= '0;
      prev_r   <= '0;
      vendor_r <= '0;
      kind_r   <= '0;
      size_r   <= '0;
      cidx_r   <= '0;
      vshift_r <= '0;
      count_r  <= '0;
      err_r    <= ERR_NONE;
      sport_r  <= '0;
      dport_r  <= '0;
      sec_r    <= '0;
      usec_r   <= '0;
      capt_r   <= '0;
      poff_r   <= '0;
      plen_r   <= '0;
    end else begin
      bpos_r   <= bpos_nxt;
      mlen_r   <= mlen_nxt;
      prev_r   <= prev_nxt;
      vendor_r <= vendor_nxt;
      kind_r   <= kind_nxt;
      size_r   <= size_nxt;
      cidx_r   <= cidx_nxt;
      vshift_r <= vshift_nxt;
      count_r  <= count_nxt;
      err_r    <= err_nxt;
      sport_r  <= sport_nxt;
      dport_r  <= dport_nxt;
      sec_r    <= sec_nxt;
      usec_r   <= usec_nxt;
      capt_r   <= capt_nxt;
      poff_r   <= poff_nxt;
      plen_r   <= plen_nxt;
    end
  end

endmodule

// ===== rtl/hcw_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcw_out_stage
// Result register: holds one status word until the sink takes it.
// ----------------------------------------------------------------------------
module hcw_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  hcw_pkg::hcw_result_t load_data,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hcw_pkg::hcw_result_t out_data
);

  logic                 valid_r, valid_nxt;
  hcw_pkg::hcw_result_t data_r,  data_nxt;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = load_data;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

endmodule

// ===== rtl/hep3_chunk_walker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hep3_chunk_walker_unit
// Byte-serial HEPv3 message checker with one status word per message.
// ----------------------------------------------------------------------------
// Feed one HEPv3 message a byte per word, in order, with tlast on its final
// byte; one status word comes out per message, nothing for the other bytes.
// The block takes a byte every clock unless a waiting status word stalls it:
// an accepted byte is held in the input register, the update of the parse
// state (magic, total length, chunk header walk, value capture) runs from
// that register, and on a tlast byte the status word is loaded into the
// output register when the parser takes that byte.
// The parse-state update sets the rate. A waiting status word only
// stalls the input when a further tlast byte reaches the parser, so plain
// message bytes keep flowing. No start-up clearing is needed after reset.
// min_elements (reset 9) is written through cfg_wr_en/cfg_wr_data; the user
// must write it only between messages, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module hep3_chunk_walker_unit (
  input  logic         clk,
  input  logic         rst_n,
  // configuration: min_elements
  input  logic         cfg_wr_en,
  input  logic [4:0]   cfg_wr_data,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] message_byte
  input  logic         in_tlast,   // last_byte
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] status, [7:3] element_count, [23:8] source_port,
  // [39:24] destination_port, [71:40] seconds, [103:72] microseconds,
  // [135:104] capture_id, [151:136] payload_offset, [167:152] payload_length
  output logic [167:0] out_tdata
);

  logic [hcw_pkg::CountW-1:0] min_elem_r;

  hcw_pkg::hcw_item_t   in_item;
  hcw_pkg::hcw_item_t   held_item;
  hcw_pkg::hcw_result_t result;
  hcw_pkg::hcw_result_t out_result;
  logic                 held_valid;
  logic                 step;
  logic                 res_fire;
  logic                 out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_elem_r <= hcw_pkg::MinElementsReset;
    end else if (cfg_wr_en) begin
      min_elem_r <= cfg_wr_data;
    end
  end

  assign in_item.message_byte = in_tdata;
  assign in_item.last_byte    = in_tlast;

  // A byte moves on unless it would produce a word the output cannot hold
  assign step = held_valid && (!held_item.last_byte || out_free);

  hcw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  hcw_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .item         (held_item),
    .min_elements (min_elem_r),
    .res_fire     (res_fire),
    .result       (result)
  );

  hcw_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_fire),
    .load_data (result),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_result)
  );

  assign out_tdata = out_result;

  // status words are never loaded into a full output register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> out_free)
    else $error("result loaded while output register busy");

  // a status word only appears after a tlast byte reached the parser
  a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(res_fire))
    else $error("result word without a last byte");

  // an empty output register never stalls the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // an ok status implies the element count met the threshold
  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_result.status == hcw_pkg::ST_OK) |->
      out_result.element_count >= min_elem_r)
    else $error("ok status with too few elements");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= hcw_pkg::ST_TRUNCATED)
    else $error("undefined status code");

endmodule
